### rtl/wsd_pkg.sv
package wsd_pkg;

	// Frame opcodes
	localparam logic [3:0] OP_CONT  = 4'h0;
	localparam logic [3:0] OP_TEXT  = 4'h1;
	localparam logic [3:0] OP_BIN   = 4'h2;
	localparam logic [3:0] OP_CLOSE = 4'h8;
	localparam logic [3:0] OP_PING  = 4'h9;

	// Length field codes and limits
	localparam logic [6:0]  LEN_EXT16     = 7'd126;
	localparam logic [2:0]  EXT16_LAST    = 3'd1;
	localparam logic [2:0]  EXT64_LAST    = 3'd7;
	localparam logic [63:0] PING_MAX_LEN  = 64'd125;
	localparam logic [15:0] CODE_PROTOCOL = 16'd1002;
	localparam logic [15:0] CODE_NONE     = 16'd0;

	// Transmitted frame bytes
	localparam logic [7:0] TX_CLOSE_HDR = 8'h88;
	localparam logic [7:0] TX_CLOSE_LEN = 8'h02;
	localparam logic [7:0] TX_PONG_HDR  = 8'h8A;

	// Result event codes
	localparam logic [1:0] EV_PAYLOAD = 2'd0;
	localparam logic [1:0] EV_EMPTY   = 2'd1;
	localparam logic [1:0] EV_TX      = 2'd2;
	localparam logic [1:0] EV_CLOSED  = 2'd3;

	// Command queue
	localparam int CMD_DEPTH = 4;
	localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
	localparam int CMD_CNT_W = CMD_PTR_W + 1;

	// Expansion steps
	localparam int STEP_W = 3;
	localparam logic [STEP_W-1:0] STEP_FIRST      = 3'd0;
	localparam logic [STEP_W-1:0] STEP_PONG_LAST  = 3'd1;
	localparam logic [STEP_W-1:0] STEP_CODE_HI    = 3'd2;
	localparam logic [STEP_W-1:0] STEP_CODE_LO    = 3'd3;
	localparam logic [STEP_W-1:0] STEP_CLOSE_LAST = 3'd4;

	typedef enum logic [2:0] {
		PH_FLAGS,
		PH_LEN0,
		PH_EXT,
		PH_MASK,
		PH_PAYLOAD
	} phase_t;

	typedef enum logic [2:0] {
		CMD_DATA,
		CMD_EMPTY,
		CMD_TX,
		CMD_PONG,
		CMD_CLOSE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  data;
		logic        bin;
		logic        more;
		logic [15:0] reason;
	} cmd_t;

endpackage

### rtl/wsd_in_if.sv
interface wsd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

### rtl/wsd_out_if.sv
interface wsd_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  event_res;
	logic [7:0]  out_byte;
	logic        is_binary;
	logic        more_follows;
	logic [15:0] close_reason;
	logic        last;

	modport source (output valid, output event_res, output out_byte, output is_binary,
		output more_follows, output close_reason, output last, input ready);
	modport sink (input valid, input event_res, input out_byte, input is_binary,
		input more_follows, input close_reason, input last, output ready);
endinterface

### rtl/websocket_frame_deframer_unit.sv
// Channel     Dir   Payload                                                 Handshake
// byte_ch     in    in_byte[7:0]                                            valid/ready
// result_ch   out   event_res[1:0] out_byte[7:0] is_binary more_follows     valid/ready
//                   close_reason[15:0] last
//
// One received word is taken per cycle while the four-entry command queue has room.
// Payload, empty-message and echo words give one result each at one per cycle while
// result_ch is ready; a pong header gives two and a close five, so the result
// sequencer sets the sustained rate. A word's command passes through the command
// queue and then the output word register before its first result is offered.
// arst_n clears the parser, queue pointers and output valid; no clearing pass is needed.
// Once closed, byte_ch stays ready and every word is dropped until reset.
module websocket_frame_deframer_unit (
	input  logic      clk,
	input  logic      arst_n,
	wsd_in_if.sink    byte_ch,
	wsd_out_if.source result_ch
);

	wsd_pkg::cmd_t cmd, head;
	logic          push, full, pop, empty;

	wsd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (byte_ch),
		.cmd    (cmd),
		.push   (push),
		.full   (full)
	);

	wsd_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (cmd),
		.full   (full),
		.pop    (pop),
		.head   (head),
		.empty  (empty)
	);

	wsd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.out_ch (result_ch)
	);

endmodule

### rtl/wsd_front.sv
// Parser: one word per cycle unless queue full, at most one command per word
module wsd_front (
	input  logic          clk,
	input  logic          arst_n,
	wsd_in_if.sink        in_ch,
	output wsd_pkg::cmd_t cmd,
	output logic          push,
	input  logic          full
);

	wsd_pkg::phase_t phase_q, phase_nx;
	logic [7:0]  flags_q, flags_nx;
	logic [7:0]  slen_q, slen_nx;
	logic [63:0] rem_q, rem_nx, rem_dec;
	logic [7:0]  key_q [4];
	logic [7:0]  key_nx [4];
	logic [1:0]  idx_q, idx_nx;
	logic [2:0]  ext_cnt_q, ext_cnt_nx;
	logic [7:0]  reason_hi_q, reason_hi_nx;
	logic        reason_seen_q, reason_seen_nx;
	logic        closed_q, closed_nx;
	logic        take, cmd_vld, hdr_done, ext_last;
	logic [7:0]  b, u;
	logic [3:0]  op;

	function automatic wsd_pkg::cmd_t mk_cmd(wsd_pkg::cmd_kind_t k, logic [7:0] d,
		logic bin, logic more, logic [15:0] r);
		wsd_pkg::cmd_t c;
		c.kind   = k;
		c.data   = d;
		c.bin    = bin;
		c.more   = more;
		c.reason = r;
		return c;
	endfunction

	// Drop everything once closed, otherwise wait for queue room
	assign in_ch.ready = closed_q || !full;
	assign take        = in_ch.valid && in_ch.ready && !closed_q;
	assign push        = take && cmd_vld;

	assign b        = in_ch.in_byte;
	assign op       = flags_q[3:0];
	assign u        = b ^ key_q[idx_q];
	assign rem_dec  = (rem_q != 64'd0) ? rem_q - 64'd1 : rem_q;
	assign ext_last = (slen_q[6:0] == wsd_pkg::LEN_EXT16 && ext_cnt_q == wsd_pkg::EXT16_LAST)
		|| ext_cnt_q == wsd_pkg::EXT64_LAST;

	// Next state and command
	always_comb begin
		phase_nx       = phase_q;
		flags_nx       = flags_q;
		slen_nx        = slen_q;
		rem_nx         = rem_q;
		key_nx         = key_q;
		idx_nx         = idx_q;
		ext_cnt_nx     = ext_cnt_q;
		reason_hi_nx   = reason_hi_q;
		reason_seen_nx = reason_seen_q;
		closed_nx      = closed_q;
		cmd_vld        = 1'b0;
		cmd            = mk_cmd(wsd_pkg::CMD_DATA, 8'd0, 1'b0, 1'b0, wsd_pkg::CODE_NONE);
		hdr_done       = 1'b0;

		case (phase_q)
			wsd_pkg::PH_FLAGS: begin
				flags_nx       = b;
				idx_nx         = 2'd0;
				key_nx         = '{default: 8'd0};
				reason_hi_nx   = 8'd0;
				reason_seen_nx = 1'b0;
				phase_nx       = wsd_pkg::PH_LEN0;
			end
			wsd_pkg::PH_LEN0: begin
				slen_nx = b;
				if (b[6:0] >= wsd_pkg::LEN_EXT16) begin
					rem_nx     = 64'd0;
					ext_cnt_nx = 3'd0;
					phase_nx   = wsd_pkg::PH_EXT;
				end else begin
					rem_nx = {57'd0, b[6:0]};
					if (b[7])
						phase_nx = wsd_pkg::PH_MASK;
					else
						hdr_done = 1'b1;
				end
			end
			wsd_pkg::PH_EXT: begin
				rem_nx = {rem_q[55:0], b};
				if (ext_last) begin
					if (slen_q[7])
						phase_nx = wsd_pkg::PH_MASK;
					else
						hdr_done = 1'b1;
				end else begin
					ext_cnt_nx = ext_cnt_q + 3'd1;
				end
			end
			wsd_pkg::PH_MASK: begin
				key_nx[idx_q] = b;
				idx_nx        = idx_q + 2'd1;
				if (idx_q == 2'd3)
					hdr_done = 1'b1;
			end
			wsd_pkg::PH_PAYLOAD: begin
				idx_nx   = idx_q + 2'd1;
				rem_nx   = rem_dec;
				phase_nx = (rem_dec == 64'd0) ? wsd_pkg::PH_FLAGS : wsd_pkg::PH_PAYLOAD;
				if (op == wsd_pkg::OP_PING) begin
					cmd_vld = 1'b1;
					cmd     = mk_cmd(wsd_pkg::CMD_TX, u, 1'b0, 1'b0, wsd_pkg::CODE_NONE);
				end else if (op inside {wsd_pkg::OP_CONT, wsd_pkg::OP_TEXT, wsd_pkg::OP_BIN}) begin
					cmd_vld = 1'b1;
					cmd     = mk_cmd(wsd_pkg::CMD_DATA, u, op == wsd_pkg::OP_BIN,
						!flags_q[7], wsd_pkg::CODE_NONE);
				end else if (op == wsd_pkg::OP_CLOSE) begin
					if (reason_seen_q) begin
						cmd_vld   = 1'b1;
						closed_nx = 1'b1;
						cmd       = mk_cmd(wsd_pkg::CMD_CLOSE, 8'd0, 1'b0, 1'b0,
							{reason_hi_q, u});
					end else begin
						reason_hi_nx   = u;
						reason_seen_nx = 1'b1;
						if (rem_dec == 64'd0) begin
							cmd_vld   = 1'b1;
							closed_nx = 1'b1;
							cmd       = mk_cmd(wsd_pkg::CMD_CLOSE, 8'd0, 1'b0, 1'b0,
								wsd_pkg::CODE_NONE);
						end
					end
				end
			end
			default: begin
				phase_nx = wsd_pkg::PH_FLAGS;
			end
		endcase

		// End of header: decide what the frame does
		if (hdr_done) begin
			phase_nx = (rem_nx == 64'd0) ? wsd_pkg::PH_FLAGS : wsd_pkg::PH_PAYLOAD;
			if (op == wsd_pkg::OP_PING) begin
				cmd_vld = 1'b1;
				if (rem_nx > wsd_pkg::PING_MAX_LEN) begin
					closed_nx = 1'b1;
					cmd       = mk_cmd(wsd_pkg::CMD_CLOSE, 8'd0, 1'b0, 1'b0,
						wsd_pkg::CODE_PROTOCOL);
				end else begin
					cmd = mk_cmd(wsd_pkg::CMD_PONG, rem_nx[7:0], 1'b0, 1'b0,
						wsd_pkg::CODE_NONE);
				end
			end else if (op inside {wsd_pkg::OP_CONT, wsd_pkg::OP_TEXT, wsd_pkg::OP_BIN}) begin
				if (!slen_nx[7]) begin
					cmd_vld   = 1'b1;
					closed_nx = 1'b1;
					cmd       = mk_cmd(wsd_pkg::CMD_CLOSE, 8'd0, 1'b0, 1'b0,
						wsd_pkg::CODE_PROTOCOL);
				end else if (rem_nx == 64'd0) begin
					cmd_vld = 1'b1;
					cmd     = mk_cmd(wsd_pkg::CMD_EMPTY, 8'd0, op == wsd_pkg::OP_BIN,
						!flags_q[7], wsd_pkg::CODE_NONE);
				end
			end else if (op == wsd_pkg::OP_CLOSE && rem_nx == 64'd0) begin
				cmd_vld   = 1'b1;
				closed_nx = 1'b1;
				cmd       = mk_cmd(wsd_pkg::CMD_CLOSE, 8'd0, 1'b0, 1'b0, wsd_pkg::CODE_NONE);
			end
		end
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= wsd_pkg::PH_FLAGS;
			flags_q       <= 8'd0;
			slen_q        <= 8'd0;
			rem_q         <= 64'd0;
			key_q         <= '{default: 8'd0};
			idx_q         <= 2'd0;
			ext_cnt_q     <= 3'd0;
			reason_hi_q   <= 8'd0;
			reason_seen_q <= 1'b0;
			closed_q      <= 1'b0;
		end else if (take) begin
			phase_q       <= phase_nx;
			flags_q       <= flags_nx;
			slen_q        <= slen_nx;
			rem_q         <= rem_nx;
			key_q         <= key_nx;
			idx_q         <= idx_nx;
			ext_cnt_q     <= ext_cnt_nx;
			reason_hi_q   <= reason_hi_nx;
			reason_seen_q <= reason_seen_nx;
			closed_q      <= closed_nx;
		end
	end

	// Closed is sticky until reset
	a_closed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		closed_q |=> closed_q)
		else $error("closed flag dropped");

	// Closing only ever follows a queued close command
	a_close_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(closed_q) |-> $past(push && cmd.kind == wsd_pkg::CMD_CLOSE))
		else $error("closed without close command");

	// Never push into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("command pushed while queue full");

endmodule

### rtl/wsd_cmd_fifo.sv
// Short command queue between parser and result sequencer
module wsd_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  wsd_pkg::cmd_t wr_cmd,
	output logic          full,
	input  logic          pop,
	output wsd_pkg::cmd_t head,
	output logic          empty
);

	wsd_pkg::cmd_t mem_q [wsd_pkg::CMD_DEPTH];
	logic [wsd_pkg::CMD_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [wsd_pkg::CMD_CNT_W-1:0] count_q;

	assign full  = count_q == wsd_pkg::CMD_CNT_W'(wsd_pkg::CMD_DEPTH);
	assign empty = count_q == '0;
	assign head  = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_cmd;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### rtl/wsd_back.sv
// Result sequencer: expands each queued command into one to five result words
module wsd_back (
	input  logic          clk,
	input  logic          arst_n,
	input  wsd_pkg::cmd_t head,
	input  logic          empty,
	output logic          pop,
	wsd_out_if.source     out_ch
);

	logic [wsd_pkg::STEP_W-1:0] step_q;
	logic        load, fin;
	logic        vld_q;
	logic [1:0]  ev_q, ev_nx;
	logic [7:0]  byte_q, byte_nx;
	logic        bin_q, bin_nx;
	logic        more_q, more_nx;
	logic [15:0] reason_q, reason_nx;
	logic        last_q;

	assign load = !empty && (!vld_q || out_ch.ready);
	assign pop  = load && fin;

	// Word for the current step of the head command
	always_comb begin
		ev_nx     = wsd_pkg::EV_TX;
		byte_nx   = 8'd0;
		bin_nx    = 1'b0;
		more_nx   = 1'b0;
		reason_nx = wsd_pkg::CODE_NONE;
		fin       = 1'b1;
		case (head.kind)
			wsd_pkg::CMD_DATA: begin
				ev_nx   = wsd_pkg::EV_PAYLOAD;
				byte_nx = head.data;
				bin_nx  = head.bin;
				more_nx = head.more;
			end
			wsd_pkg::CMD_EMPTY: begin
				ev_nx   = wsd_pkg::EV_EMPTY;
				bin_nx  = head.bin;
				more_nx = head.more;
			end
			wsd_pkg::CMD_TX: begin
				byte_nx = head.data;
			end
			wsd_pkg::CMD_PONG: begin
				fin     = step_q == wsd_pkg::STEP_PONG_LAST;
				byte_nx = fin ? head.data : wsd_pkg::TX_PONG_HDR;
			end
			wsd_pkg::CMD_CLOSE: begin
				reason_nx = head.reason;
				fin       = step_q == wsd_pkg::STEP_CLOSE_LAST;
				case (step_q)
					wsd_pkg::STEP_FIRST:      byte_nx = wsd_pkg::TX_CLOSE_HDR;
					wsd_pkg::STEP_PONG_LAST:  byte_nx = wsd_pkg::TX_CLOSE_LEN;
					wsd_pkg::STEP_CODE_HI:    byte_nx = head.reason[15:8];
					wsd_pkg::STEP_CODE_LO:    byte_nx = head.reason[7:0];
					wsd_pkg::STEP_CLOSE_LAST: ev_nx = wsd_pkg::EV_CLOSED;
					default:                  byte_nx = 8'd0;
				endcase
			end
			default: begin
				fin = 1'b1;
			end
		endcase
	end

	// Step counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= wsd_pkg::STEP_FIRST;
			vld_q  <= 1'b0;
		end else begin
			if (load)
				step_q <= fin ? wsd_pkg::STEP_FIRST : step_q + 1'b1;
			if (load)
				vld_q <= 1'b1;
			else if (out_ch.ready)
				vld_q <= 1'b0;
		end
	end

	// Output word register
	always_ff @(posedge clk) begin
		if (load) begin
			ev_q     <= ev_nx;
			byte_q   <= byte_nx;
			bin_q    <= bin_nx;
			more_q   <= more_nx;
			reason_q <= reason_nx;
			last_q   <= fin;
		end
	end

	assign out_ch.valid        = vld_q;
	assign out_ch.event_res    = ev_q;
	assign out_ch.out_byte     = byte_q;
	assign out_ch.is_binary    = bin_q;
	assign out_ch.more_follows = more_q;
	assign out_ch.close_reason = reason_q;
	assign out_ch.last         = last_q;

	// Mid-expansion the command stays at the head
	a_hold_head: assert property (@(posedge clk) disable iff (!arst_n)
		step_q != wsd_pkg::STEP_FIRST |-> !empty)
		else $error("command lost during expansion");

	// Only multi-word commands advance the step
	a_step_kind: assert property (@(posedge clk) disable iff (!arst_n)
		step_q != wsd_pkg::STEP_FIRST |->
			(head.kind == wsd_pkg::CMD_PONG || head.kind == wsd_pkg::CMD_CLOSE))
		else $error("step advanced on single-word command");

	// A closed event always ends its input word's results
	a_closed_last: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q && ev_q == wsd_pkg::EV_CLOSED |-> last_q)
		else $error("closed event not marked last");

endmodule

### test/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// Length field forms and header bits
	localparam int         FORM_7         = 0;
	localparam int         FORM_16        = 1;
	localparam int         FORM_64        = 2;
	localparam logic [6:0] LEN_EXT64      = 7'd127;
	localparam logic [3:0] OP_PONG        = 4'hA;
	localparam logic [2:0] MASK_LAST_STEP = 3'd3;

	localparam int RANDOM_WORDS = 60;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int REPORT_MAX   = 10;

	typedef struct packed {
		logic [1:0]  event_res;
		logic [7:0]  out_byte;
		logic        is_binary;
		logic        more_follows;
		logic [15:0] close_reason;
		logic        last;
	} result_t;

	typedef struct {
		logic [7:0] data;
		bit         hold;
	} rx_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	wsd_in_if  byte_if ();
	wsd_out_if res_if ();

	websocket_frame_deframer_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_ch   (byte_if),
		.result_ch (res_if)
	);

	always #1ns clk = ~clk;

	rx_word_t rx_stream [$];
	result_t  owed_results [$];

	int mismatches  = 0;
	int cycle_count = 0;
	int tx_gap      = 0;
	int tx_calm     = 0;
	int rx_stall    = 0;
	int rx_calm     = 0;

	// Parser state mirror
	wsd_pkg::phase_t ps_phase;
	logic [7:0]  ps_flags;
	logic [7:0]  ps_len0;
	logic [63:0] ps_remain;
	logic [7:0]  ps_key [4];
	logic [1:0]  ps_key_idx;
	logic [2:0]  ps_step;
	logic [7:0]  ps_reason_hi;
	logic [1:0]  ps_reason_cnt;
	logic        ps_closed;

	// Idle lengths: mostly short, a few long, with occasional calm stretches
	function automatic int pick_idle(ref int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) begin
			calm = $urandom_range(10, 40);
			return 0;
		end
		if (r < 50)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic void owe(logic [1:0] ev, logic [7:0] data, logic bin, logic more,
		logic [15:0] reason);
		result_t r;
		r = '{ev, data, bin, more, reason, 1'b0};
		owed_results.push_back(r);
	endfunction

	// Close frame on the transmit side, then the closed event
	function automatic void owe_close(logic [15:0] code);
		owe(wsd_pkg::EV_TX, wsd_pkg::TX_CLOSE_HDR, 1'b0, 1'b0, code);
		owe(wsd_pkg::EV_TX, wsd_pkg::TX_CLOSE_LEN, 1'b0, 1'b0, code);
		owe(wsd_pkg::EV_TX, code[15:8], 1'b0, 1'b0, code);
		owe(wsd_pkg::EV_TX, code[7:0], 1'b0, 1'b0, code);
		owe(wsd_pkg::EV_CLOSED, 8'h00, 1'b0, 1'b0, code);
		ps_closed = 1'b1;
	endfunction

	function automatic bit is_data_op(logic [3:0] op);
		return op == wsd_pkg::OP_CONT || op == wsd_pkg::OP_TEXT || op == wsd_pkg::OP_BIN;
	endfunction

	function automatic void end_of_header();
		logic [3:0] op;
		op = ps_flags[3:0];
		if (op == wsd_pkg::OP_PING) begin
			if (ps_remain > wsd_pkg::PING_MAX_LEN) begin
				owe_close(wsd_pkg::CODE_PROTOCOL);
				return;
			end
			owe(wsd_pkg::EV_TX, wsd_pkg::TX_PONG_HDR, 1'b0, 1'b0, wsd_pkg::CODE_NONE);
			owe(wsd_pkg::EV_TX, ps_remain[7:0], 1'b0, 1'b0, wsd_pkg::CODE_NONE);
		end else if (is_data_op(op)) begin
			// data frames from a client must be masked
			if (!ps_len0[7]) begin
				owe_close(wsd_pkg::CODE_PROTOCOL);
				return;
			end
			if (ps_remain == 0)
				owe(wsd_pkg::EV_EMPTY, 8'h00, op == wsd_pkg::OP_BIN, !ps_flags[7],
					wsd_pkg::CODE_NONE);
		end else if (op == wsd_pkg::OP_CLOSE && ps_remain == 0) begin
			owe_close(wsd_pkg::CODE_NONE);
			return;
		end
		ps_phase = (ps_remain == 0) ? wsd_pkg::PH_FLAGS : wsd_pkg::PH_PAYLOAD;
	endfunction

	function automatic void after_length();
		if (ps_len0[7]) begin
			ps_phase = wsd_pkg::PH_MASK;
			ps_step  = '0;
		end else
			end_of_header();
	endfunction

	// Works out the results owed for one accepted word
	function automatic void deframe_byte(logic [7:0] b);
		int         n_owed;
		logic [3:0] op;
		logic [7:0] u;
		n_owed = owed_results.size();
		if (ps_closed)
			return;
		case (ps_phase)
			wsd_pkg::PH_FLAGS: begin
				ps_flags      = b;
				ps_key_idx    = '0;
				ps_key        = '{default: 8'h00};
				ps_reason_hi  = 8'h00;
				ps_reason_cnt = '0;
				ps_phase      = wsd_pkg::PH_LEN0;
			end
			wsd_pkg::PH_LEN0: begin
				ps_len0 = b;
				if (b[6:0] >= wsd_pkg::LEN_EXT16) begin
					ps_remain = '0;
					ps_step   = '0;
					ps_phase  = wsd_pkg::PH_EXT;
				end else begin
					ps_remain = {57'd0, b[6:0]};
					after_length();
				end
			end
			wsd_pkg::PH_EXT: begin
				ps_remain = {ps_remain[55:0], b};
				if ((ps_len0[6:0] == wsd_pkg::LEN_EXT16 && ps_step == wsd_pkg::EXT16_LAST) ||
					ps_step == wsd_pkg::EXT64_LAST)
					after_length();
				else
					ps_step++;
			end
			wsd_pkg::PH_MASK: begin
				ps_key[ps_step[1:0]] = b;
				if (ps_step == MASK_LAST_STEP)
					end_of_header();
				else
					ps_step++;
			end
			wsd_pkg::PH_PAYLOAD: begin
				op = ps_flags[3:0];
				u  = b ^ ps_key[ps_key_idx];
				ps_key_idx++;
				if (ps_remain != 0)
					ps_remain--;
				if (op == wsd_pkg::OP_PING)
					owe(wsd_pkg::EV_TX, u, 1'b0, 1'b0, wsd_pkg::CODE_NONE);
				else if (is_data_op(op))
					owe(wsd_pkg::EV_PAYLOAD, u, op == wsd_pkg::OP_BIN, !ps_flags[7],
						wsd_pkg::CODE_NONE);
				else if (op == wsd_pkg::OP_CLOSE) begin
					// status code: high byte first, close on the second byte
					if (ps_reason_cnt == 0) begin
						ps_reason_hi  = u;
						ps_reason_cnt = 2'd1;
					end else begin
						ps_reason_cnt = 2'd2;
						owe_close({ps_reason_hi, u});
					end
					if (!ps_closed && ps_remain == 0)
						owe_close(wsd_pkg::CODE_NONE);
				end
				if (!ps_closed && ps_remain == 0)
					ps_phase = wsd_pkg::PH_FLAGS;
			end
			default: ;
		endcase
		if (owed_results.size() > n_owed)
			owed_results[owed_results.size() - 1].last = 1'b1;
	endfunction

	// Stimulus helpers
	function automatic void push_word(logic [7:0] b, bit hold);
		rx_stream.push_back('{b, hold});
	endfunction

	function automatic logic [7:0] make_flags(logic fin, logic [3:0] op);
		return {fin, 3'($urandom_range(0, 7)), op};
	endfunction

	function automatic int pick_form();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7)
			return FORM_7;
		return (r < 9) ? FORM_16 : FORM_64;
	endfunction

	function automatic logic [3:0] pick_data_op();
		case ($urandom_range(0, 2))
			0: return wsd_pkg::OP_CONT;
			1: return wsd_pkg::OP_TEXT;
			default: return wsd_pkg::OP_BIN;
		endcase
	endfunction

	function automatic logic [3:0] pick_skipped_op();
		int r;
		r = $urandom_range(0, 10);
		if (r == 0)
			return OP_PONG;
		return (r <= 5) ? 4'(r + 2) : 4'(r + 5);
	endfunction

	// Queues one frame header and n_pay payload words of random content
	function automatic void add_frame(logic [7:0] flags, logic [63:0] len, int form,
		bit masked, int n_pay, bit hold);
		logic [7:0] len0;
		push_word(flags, hold);
		len0[7] = masked;
		if (form == FORM_7)
			len0[6:0] = len[6:0];
		else
			len0[6:0] = (form == FORM_16) ? wsd_pkg::LEN_EXT16 : LEN_EXT64;
		push_word(len0, 1'b0);
		if (form == FORM_16) begin
			push_word(len[15:8], 1'b0);
			push_word(len[7:0], 1'b0);
		end else if (form == FORM_64) begin
			for (int i = 7; i >= 0; i--)
				push_word(len[i*8 +: 8], 1'b0);
		end
		if (masked)
			repeat (4) push_word(8'($urandom), 1'b0);
		repeat (n_pay) push_word(8'($urandom), 1'b0);
	endfunction

	// Extended forms carry short lengths too, which must be taken as they stand
	function automatic logic [63:0] pick_len(int form);
		if (form != FORM_7)
			return $urandom_range(0, 12);
		return $urandom_range(0, 8);
	endfunction

	// Driver: offers queued words, predicts on each accepted one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_if.valid   <= 1'b0;
			byte_if.in_byte <= 8'h00;
			tx_gap = 0;
		end else begin
			if (byte_if.valid && byte_if.ready)
				deframe_byte(byte_if.in_byte);
			if (!byte_if.valid || byte_if.ready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					byte_if.valid <= 1'b0;
				end else if (rx_stream.size() > 0 &&
					!(rx_stream[0].hold && owed_results.size() > 0)) begin
					byte_if.valid   <= 1'b1;
					byte_if.in_byte <= rx_stream[0].data;
					void'(rx_stream.pop_front());
					tx_gap = pick_idle(tx_calm);
				end else
					byte_if.valid <= 1'b0;
			end
		end
	end

	// Monitor: random back-pressure, checks each result against the oldest owed one
	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			res_if.ready <= 1'b0;
			rx_stall = 0;
		end else begin
			if (res_if.valid && res_if.ready) begin
				got = '{res_if.event_res, res_if.out_byte, res_if.is_binary,
					res_if.more_follows, res_if.close_reason, res_if.last};
				if (owed_results.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("%0t: result with none owed: ev=%0d byte=%02h bin=%b more=%b reason=%0d last=%b",
							$realtime, got.event_res, got.out_byte, got.is_binary,
							got.more_follows, got.close_reason, got.last);
				end else begin
					want = owed_results.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= REPORT_MAX) begin
							$display("%0t: ev=%0d byte=%02h bin=%b more=%b reason=%0d last=%b",
								$realtime, got.event_res, got.out_byte, got.is_binary,
								got.more_follows, got.close_reason, got.last);
							$display("  wanted ev=%0d byte=%02h bin=%b more=%b reason=%0d last=%b",
								want.event_res, want.out_byte, want.is_binary,
								want.more_follows, want.close_reason, want.last);
						end
					end
				end
			end
			if (rx_stall > 0) begin
				rx_stall--;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= 1'b1;
				rx_stall = pick_idle(rx_calm);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("websocket_frame_deframer_unit: mismatch");
			$finish;
		end
	end

	// Stimulus and end of run
	initial begin
		int          frames;
		int          form;
		int          n;
		logic [63:0] len;
		bit          masked;

		byte_if.valid   = 1'b0;
		byte_if.in_byte = 8'h00;
		res_if.ready    = 1'b0;

		ps_phase      = wsd_pkg::PH_FLAGS;
		ps_flags      = 8'h00;
		ps_len0       = 8'h00;
		ps_remain     = '0;
		ps_key        = '{default: 8'h00};
		ps_key_idx    = '0;
		ps_step       = '0;
		ps_reason_hi  = 8'h00;
		ps_reason_cnt = '0;
		ps_closed     = 1'b0;

		// directed: empty message, fragment, continuation, unmasked control frames
		add_frame(make_flags(1'b1, wsd_pkg::OP_TEXT), 0, FORM_7, 1'b1, 0, 1'b0);
		add_frame(make_flags(1'b0, wsd_pkg::OP_BIN), 1, FORM_7, 1'b1, 1, 1'b0);
		add_frame(make_flags(1'b1, wsd_pkg::OP_CONT), 1, FORM_7, 1'b1, 1, 1'b0);
		add_frame(make_flags(1'b1, wsd_pkg::OP_PING), 1, FORM_7, 1'b0, 1, 1'b0);
		add_frame(make_flags(1'b1, OP_PONG), 1, FORM_7, 1'b0, 1, 1'b0);
		add_frame(make_flags(1'b1, pick_skipped_op()), 0, FORM_7, 1'b0, 0, 1'b0);

		// random well-formed frames; one pauses until all results are in
		frames = 0;
		while (rx_stream.size() < RANDOM_WORDS) begin
			n    = $urandom_range(0, 19);
			form = pick_form();
			if (n < 12) begin
				len = pick_len(form);
				add_frame(make_flags($urandom_range(0, 1), pick_data_op()), len, form,
					1'b1, int'(len), frames == 3);
			end else if (n < 16) begin
				len = $urandom_range(0, 6);
				add_frame(make_flags($urandom_range(0, 1), wsd_pkg::OP_PING), len, form,
					$urandom_range(0, 1), int'(len), frames == 3);
			end else begin
				len = $urandom_range(0, 4);
				add_frame(make_flags($urandom_range(0, 1), pick_skipped_op()), len, form,
					$urandom_range(0, 1), int'(len), frames == 3);
			end
			frames++;
		end

		// one closing frame ends the session, then a few words that must be dropped
		masked = $urandom_range(0, 1);
		case ($urandom_range(0, 3))
			0: begin
				n = $urandom_range(2, 5);
				add_frame(make_flags(1'b1, wsd_pkg::OP_CLOSE), n, pick_form(), masked, n,
					1'b1);
			end
			1: begin
				n = $urandom_range(0, 1);
				add_frame(make_flags(1'b1, wsd_pkg::OP_CLOSE), n, pick_form(), masked, n,
					1'b1);
			end
			2: begin
				n = $urandom_range(0, 2);
				if (n == 0)
					add_frame(make_flags(1'b1, wsd_pkg::OP_PING), 126, FORM_16, masked, 3,
						1'b1);
				else if (n == 1)
					add_frame(make_flags(1'b1, wsd_pkg::OP_PING), $urandom_range(127, 65535),
						FORM_16, masked, 3, 1'b1);
				else begin
					len = {32'($urandom), 32'($urandom)};
					if (len < 126)
						len = 126;
					add_frame(make_flags(1'b1, wsd_pkg::OP_PING), len, FORM_64, masked, 3,
						1'b1);
				end
			end
			default: begin
				form = pick_form();
				len  = $urandom_range(0, 8);
				add_frame(make_flags($urandom_range(0, 1), pick_data_op()), len, form,
					1'b0, int'(len), 1'b1);
			end
		endcase
		repeat (4) push_word(8'($urandom), 1'b0);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (rx_stream.size() != 0 || byte_if.valid || owed_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && owed_results.size() == 0)
			$display("websocket_frame_deframer_unit: match");
		else
			$display("websocket_frame_deframer_unit: mismatch");
		$finish;
	end

endmodule

### files.f
rtl/wsd_pkg.sv
rtl/wsd_in_if.sv
rtl/wsd_out_if.sv
rtl/wsd_front.sv
rtl/wsd_cmd_fifo.sv
rtl/wsd_back.sv
rtl/websocket_frame_deframer_unit.sv
test/tb_top.sv
